@@ rtl/ifd_pkg.sv @@
// Package: frame constants, result type and helpers for the IMU frame deframer.
package ifd_pkg;

  localparam int FRAME_LEN    = 11;
  localparam int WINDOW_LEN   = FRAME_LEN - 1;
  localparam int FILL_BITS    = $clog2(WINDOW_LEN + 1);
  localparam int COUNTER_BITS = 32;
  localparam int REPORT_BITS  = 32;

  localparam logic [7:0] HEADER_BYTE = 8'h55;
  localparam logic [7:0] TYPE_ANGLE  = 8'h53;

  typedef logic [COUNTER_BITS-1:0] counter_t;

  typedef struct packed {
    logic [7:0]              frame_type;
    logic signed [15:0]      axis_x;
    logic signed [15:0]      axis_y;
    logic signed [15:0]      axis_z;
    logic [15:0]             extra_word;
    logic [REPORT_BITS-1:0]  frames_seen;
    logic [REPORT_BITS-1:0]  checksum_errors;
    logic [REPORT_BITS-1:0]  angle_frames_seen;
  } frame_t;

  function automatic logic [REPORT_BITS-1:0] report_count(input counter_t c);
    logic [63:0] wide;
    wide = 64'(c);
    return wide[REPORT_BITS-1:0];
  endfunction

endpackage

@@ rtl/ifd_byte_if.sv @@
// Interface: received byte channel.
interface ifd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/ifd_frame_if.sv @@
// Interface: decoded frame channel.
interface ifd_frame_if;
  import ifd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [7:0]             frame_type;
  logic signed [15:0]     axis_x;
  logic signed [15:0]     axis_y;
  logic signed [15:0]     axis_z;
  logic [15:0]            extra_word;
  logic [REPORT_BITS-1:0] frames_seen;
  logic [REPORT_BITS-1:0] checksum_errors;
  logic [REPORT_BITS-1:0] angle_frames_seen;

  modport source (output valid, output frame_type, output axis_x, output axis_y,
                  output axis_z, output extra_word, output frames_seen,
                  output checksum_errors, output angle_frames_seen, input ready);
  modport sink   (input valid, input frame_type, input axis_x, input axis_y,
                  input axis_z, input extra_word, input frames_seen,
                  input checksum_errors, input angle_frames_seen, output ready);
endinterface

@@ rtl/imu_frame_deframer.sv @@
// Top level: input register, frame window and result register of the IMU frame deframer.
//
// Takes one received byte per cycle while rx.ready is high and emits one transaction
// per valid 11-byte frame (header 0x55, 8-bit sum of the first ten bytes equal to the
// eleventh). A byte passes through the input register and is then checked against the
// ten-byte window; a frame completed by a byte is held in the result register until
// taken. Throughput is one byte per cycle, set by the single window update path;
// rx.ready drops only while both the input register and an untaken result are held.
module imu_frame_deframer (
  input logic        clk,
  input logic        rst,
  ifd_byte_if.sink   rx,
  ifd_frame_if.source frames
);
  import ifd_pkg::*;

  logic       in_full;
  logic [7:0] in_byte;
  logic       advance;
  logic       out_free;
  logic       hit;
  frame_t     frame;
  logic       out_valid;
  frame_t     out_frame;

  assign out_free = !out_valid || frames.ready;
  assign advance  = in_full && out_free;
  assign rx.ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (rx.ready) begin
      in_full <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) in_byte <= rx.rx_byte;
  end

  ifd_window u_window (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .rx_byte (in_byte),
    .hit     (hit),
    .frame   (frame)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hit) out_frame <= frame;
  end

  assign frames.valid             = out_valid;
  assign frames.frame_type        = out_frame.frame_type;
  assign frames.axis_x            = out_frame.axis_x;
  assign frames.axis_y            = out_frame.axis_y;
  assign frames.axis_z            = out_frame.axis_z;
  assign frames.extra_word        = out_frame.extra_word;
  assign frames.frames_seen       = out_frame.frames_seen;
  assign frames.checksum_errors   = out_frame.checksum_errors;
  assign frames.angle_frames_seen = out_frame.angle_frames_seen;

endmodule

@@ rtl/ifd_window.sv @@
// Byte window, header and checksum check, frame counters.
module ifd_window (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic [7:0]      rx_byte,
  output logic            hit,
  output ifd_pkg::frame_t frame
);
  import ifd_pkg::*;

  logic [7:0]           window [WINDOW_LEN];
  logic [7:0]           window_next [WINDOW_LEN];
  logic [FILL_BITS-1:0] fill;
  logic [FILL_BITS-1:0] fill_next;
  counter_t             frame_counter;
  counter_t             frame_counter_next;
  counter_t             bad_sum_counter;
  counter_t             bad_sum_counter_next;
  counter_t             angle_counter;
  counter_t             angle_counter_next;

  logic [7:0] pair_sum [WINDOW_LEN/2];
  logic [7:0] sum;
  logic       full;
  logic       header_ok;
  logic       sum_ok;

  // pairwise adder tree over the ten leading bytes
  always_comb begin
    for (int i = 0; i < WINDOW_LEN / 2; i++) begin
      pair_sum[i] = window[2*i] + window[2*i+1];
    end
    sum = ((pair_sum[0] + pair_sum[1]) + (pair_sum[2] + pair_sum[3])) + pair_sum[4];
  end

  assign full      = (fill == FILL_BITS'(WINDOW_LEN));
  assign header_ok = (window[0] == HEADER_BYTE);
  assign sum_ok    = (sum == rx_byte);
  assign hit       = full && header_ok && sum_ok;

  always_comb begin
    window_next          = window;
    fill_next            = fill;
    frame_counter_next   = frame_counter;
    bad_sum_counter_next = bad_sum_counter;
    angle_counter_next   = angle_counter;
    if (!full) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        if (fill == FILL_BITS'(i)) window_next[i] = rx_byte;
      end
      fill_next = fill + FILL_BITS'(1);
    end else if (hit) begin
      fill_next          = '0;
      frame_counter_next = frame_counter + counter_t'(1);
      if (window[1] == TYPE_ANGLE) angle_counter_next = angle_counter + counter_t'(1);
    end else begin
      // slide by one byte
      for (int i = 0; i < WINDOW_LEN - 1; i++) begin
        window_next[i] = window[i+1];
      end
      window_next[WINDOW_LEN-1] = rx_byte;
      if (header_ok) bad_sum_counter_next = bad_sum_counter + counter_t'(1);
    end
  end

  always_comb begin
    frame.frame_type        = window[1];
    frame.axis_x            = {window[5], window[4]};
    frame.axis_y            = {window[3], window[2]};
    frame.axis_z            = {window[7], window[6]};
    frame.extra_word        = {window[9], window[8]};
    frame.frames_seen       = report_count(frame_counter_next);
    frame.checksum_errors   = report_count(bad_sum_counter_next);
    frame.angle_frames_seen = report_count(angle_counter_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill            <= '0;
      frame_counter   <= '0;
      bad_sum_counter <= '0;
      angle_counter   <= '0;
    end else if (advance) begin
      fill            <= fill_next;
      frame_counter   <= frame_counter_next;
      bad_sum_counter <= bad_sum_counter_next;
      angle_counter   <= angle_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) window <= window_next;
  end

endmodule
